// ===== rtl/mpm_pkg.sv =====
// Shared types and constants for the max-priority multiset.
// No dependencies; imported by every module of the block.
package mpm_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int KEY_W           = 32;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE
    } state_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic init;
        logic eval;
    } scan_ctl_t;

endpackage

// ===== rtl/mpm_store.sv =====
// Entry storage: one row per entry holding {count, key}.
// One write port, one read port with registered read data. Uses mpm_pkg.
module mpm_store
    import mpm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  logic [COUNT_BITS-1:0] wcount,
    input  logic [KEY_W-1:0]      wkey,
    input  logic [IDX_W-1:0]      raddr,
    output logic [COUNT_BITS-1:0] rcount,
    output logic [KEY_W-1:0]      rkey
);

    logic [COUNT_BITS+KEY_W-1:0] mem [MAX_ENTRIES];
    logic [COUNT_BITS+KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wcount, wkey};
        end
        rdata_reg <= mem[raddr];
    end

    assign rcount = rdata_reg[COUNT_BITS+KEY_W-1:KEY_W];
    assign rkey   = rdata_reg[KEY_W-1:0];

endmodule

// ===== rtl/mpm_scan.sv =====
// Shared compare unit: looks at one entry per cycle and keeps the running
// key match, lowest free entry and greatest key. Uses mpm_pkg.
module mpm_scan
    import mpm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scan_ctl_t             ctl,
    input  logic [KEY_W-1:0]      req_key,
    input  logic [IDX_W-1:0]      ent_idx,
    input  logic [COUNT_BITS-1:0] ent_count,
    input  logic [KEY_W-1:0]      ent_key,
    output logic                  match_found,
    output logic [IDX_W-1:0]      match_idx,
    output logic [COUNT_BITS-1:0] match_count,
    output logic                  free_found,
    output logic [IDX_W-1:0]      free_idx,
    output logic                  best_found,
    output logic [IDX_W-1:0]      best_idx,
    output logic [COUNT_BITS-1:0] best_count,
    output logic [KEY_W-1:0]      best_key
);

    logic                  match_found_reg, match_found_next;
    logic                  free_found_reg,  free_found_next;
    logic                  best_found_reg,  best_found_next;
    logic [IDX_W-1:0]      match_idx_reg,   match_idx_next;
    logic [IDX_W-1:0]      free_idx_reg,    free_idx_next;
    logic [IDX_W-1:0]      best_idx_reg,    best_idx_next;
    logic [COUNT_BITS-1:0] match_count_reg, match_count_next;
    logic [COUNT_BITS-1:0] best_count_reg,  best_count_next;
    logic [KEY_W-1:0]      best_key_reg,    best_key_next;
    logic                  in_use;
    logic                  is_greater;

    assign in_use     = (ent_count != '0);
    assign is_greater = ($signed(ent_key) > $signed(best_key_reg));

    always_comb
    begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_count_next = match_count_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_count_next  = best_count_reg;
        best_key_next    = best_key_reg;
        if (ctl.init)
        begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            best_found_next  = 1'b0;
        end
        else if (ctl.eval)
        begin
            if (in_use)
            begin
                if (ent_key == req_key)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = ent_idx;
                    match_count_next = ent_count;
                end
                if (!best_found_reg || is_greater)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = ent_idx;
                    best_count_next = ent_count;
                    best_key_next   = ent_key;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = ent_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            best_found_reg  <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg   <= match_idx_next;
        match_count_reg <= match_count_next;
        free_idx_reg    <= free_idx_next;
        best_idx_reg    <= best_idx_next;
        best_count_reg  <= best_count_next;
        best_key_reg    <= best_key_next;
    end

    assign match_found = match_found_reg;
    assign match_idx   = match_idx_reg;
    assign match_count = match_count_reg;
    assign free_found  = free_found_reg;
    assign free_idx    = free_idx_reg;
    assign best_found  = best_found_reg;
    assign best_idx    = best_idx_reg;
    assign best_count  = best_count_reg;
    assign best_key    = best_key_reg;

endmodule

// ===== rtl/max_priority_multiset.sv =====
// Top level of the max-priority multiset: sequencer, write-back and result.
// Depends on mpm_pkg, mpm_store and mpm_scan.
//
//  port group        dir  signals                   timing
//  request           in   start, command, key_in    taken when start & !busy
//  result            out  done, status, key_out     done high for one cycle
//
// A request keeps busy high through the scan: one read of the entry memory per
// entry through the single compare unit, a final scan step that drains the read
// register, then the write-back state. The result strobes in the same cycle that
// busy falls. After reset a clearing pass writes every entry count to zero,
// one entry a cycle, with busy high.
// The result port has no back-pressure; done is never stalled.
module max_priority_multiset
    import mpm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              command,
    input  logic [KEY_W-1:0]  key_in,
    output logic              done,
    output logic [1:0]        status,
    output logic [KEY_W-1:0]  key_out
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST_SCAN = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] LAST_CLR  = CNT_W'(MAX_ENTRIES - 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [KEY_W-1:0]   key_out_reg, key_out_next;

    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [COUNT_BITS-1:0] wcount;
    logic [KEY_W-1:0]      wkey;
    logic [IDX_W-1:0]      raddr;
    logic [COUNT_BITS-1:0] rcount;
    logic [KEY_W-1:0]      rkey;
    scan_ctl_t             scan_ctl;

    logic                  match_found, free_found, best_found;
    logic [IDX_W-1:0]      match_idx, free_idx, best_idx;
    logic [COUNT_BITS-1:0] match_count, best_count;
    logic [KEY_W-1:0]      best_key;

    mpm_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_store (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wcount (wcount),
        .wkey   (wkey),
        .raddr  (raddr),
        .rcount (rcount),
        .rkey   (rkey)
    );

    mpm_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .req_key     (key_reg),
        .ent_idx     (chk_idx_reg),
        .ent_count   (rcount),
        .ent_key     (rkey),
        .match_found (match_found),
        .match_idx   (match_idx),
        .match_count (match_count),
        .free_found  (free_found),
        .free_idx    (free_idx),
        .best_found  (best_found),
        .best_idx    (best_idx),
        .best_count  (best_count),
        .best_key    (best_key)
    );

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        key_out_next   = key_out_reg;
        chk_valid_next = 1'b0;
        we             = 1'b0;
        waddr          = idx_reg[IDX_W-1:0];
        wcount         = '0;
        wkey           = key_reg;
        raddr          = idx_reg[IDX_W-1:0];
        scan_ctl       = '0;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (idx_reg == LAST_CLR)
                begin
                    state_next = S_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = command;
                    key_next      = key_in;
                    idx_next      = '0;
                    scan_ctl.init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read of idx issued now, its data evaluated next cycle
                scan_ctl.eval  = chk_valid_reg;
                chk_valid_next = (idx_reg != LAST_SCAN);
                if (idx_reg == LAST_SCAN)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                done_next    = 1'b1;
                key_out_next = '0;
                state_next   = S_IDLE;
                if (cmd_reg == CMD_POP)
                begin
                    if (best_found)
                    begin
                        we           = 1'b1;
                        waddr        = best_idx;
                        wcount       = best_count - 1'b1;
                        wkey         = best_key;
                        status_next  = ST_POPPED;
                        key_out_next = best_key;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                else if (match_found)
                begin
                    if (match_count == '1)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        we          = 1'b1;
                        waddr       = match_idx;
                        wcount      = match_count + 1'b1;
                        status_next = ST_PUSHED;
                    end
                end
                else if (free_found)
                begin
                    we          = 1'b1;
                    waddr       = free_idx;
                    wcount      = COUNT_BITS'(1);
                    status_next = ST_PUSHED;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= idx_reg[IDX_W-1:0];
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        key_out_reg <= key_out_next;
    end

    assign done    = done_reg;
    assign status  = status_reg;
    assign key_out = key_out_reg;

`ifndef SYNTHESIS
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_WRITE))
        else $error("result strobe without a write-back cycle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == S_SCAN))
        else $error("accepted request did not start a scan");

    a_key_zero_unless_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_POPPED) |-> (key_out_reg == '0))
        else $error("key_out nonzero on a non-pop result");

    a_pop_live_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && cmd_reg == CMD_POP && best_found) |-> (best_count != '0))
        else $error("pop selected a free entry");

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == S_SCAN))
        else $error("entry evaluated outside the scan");
`endif

endmodule

// ===== tb/tb_max_priority_multiset.sv =====
`timescale 1ns / 1ps
// Testbench for max_priority_multiset: directed and random push/pop requests.
// Each result is checked against a behavioral model of the store kept here.
// Depends on mpm_pkg and the RTL of the block.
module tb_max_priority_multiset
    import mpm_pkg::*;
();

    localparam int ENTRIES = MAX_ENTRIES_DEF;
    localparam int CNT_BITS = COUNT_BITS_DEF;
    localparam longint CNT_MAX = (longint'(1) << CNT_BITS) - 1;
    localparam int REPEAT_N = 4;
    localparam int RANDOM_ITEMS = 1300;
    localparam int POOL_N = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = ENTRIES + 8;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key;
    } result_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             command;
    logic [KEY_W-1:0] key_in;
    logic             done;
    logic [1:0]       status;
    logic [KEY_W-1:0] key_out;

    // model of the store
    logic [KEY_W-1:0] held_key [ENTRIES];
    longint           held_count [ENTRIES];

    result_t pending_results[$];
    result_t want_result;
    int      errors = 0;
    int      cycles = 0;
    bit      idle_enable = 1'b1;

    // first 16 are distinct and include the signed extremes; 7 is the repeated key
    logic [KEY_W-1:0] key_pool [POOL_N] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h7FFF_FFFE, 32'h8000_0001, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678,
        32'hEDCB_A988, 32'h0000_0100, 32'hFFFF_FF00, 32'h4000_0000,
        32'hC000_0000, 32'h0000_0007, 32'h0F0F_0F0F, 32'hF0F0_F0F0
    };

    max_priority_multiset #(
        .MAX_ENTRIES (ENTRIES),
        .COUNT_BITS  (CNT_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .key_in  (key_in),
        .done    (done),
        .status  (status),
        .key_out (key_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            held_key[i]   = '0;
            held_count[i] = 0;
        end
    end

    // Applies one request to the model store and returns the result it must give.
    function automatic result_t apply_to_store(logic cmd, logic [KEY_W-1:0] key);
        result_t r;
        int      hit;
        int      free_idx;
        int      best;
        r.status = ST_PUSHED;
        r.key    = '0;
        hit      = -1;
        free_idx = -1;
        best     = -1;
        if (cmd == CMD_PUSH)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (held_count[i] != 0 && held_key[i] == key)
                    hit = i;
                else if (held_count[i] == 0 && free_idx < 0)
                    free_idx = i;
            end
            if (hit >= 0)
            begin
                if (held_count[hit] >= CNT_MAX)
                    r.status = ST_FULL;
                else
                    held_count[hit]++;
            end
            else if (free_idx < 0)
                r.status = ST_FULL;
            else
            begin
                held_key[free_idx]   = key;
                held_count[free_idx] = 1;
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (held_count[i] != 0 &&
                    (best < 0 || $signed(held_key[i]) > $signed(held_key[best])))
                    best = i;
            end
            if (best < 0)
                r.status = ST_EMPTY;
            else
            begin
                r.status = ST_POPPED;
                r.key    = held_key[best];
                held_count[best]--;
            end
        end
        return r;
    endfunction

    // Holds the request until the block takes it; start stays high for a
    // back-to-back request unless an idle gap is drawn.
    task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key);
        start   <= 1'b1;
        command <= cmd;
        key_in  <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_to_store(cmd, key));
        if (idle_enable && $urandom_range(99) < 26)
        begin
            start   <= 1'b0;
            command <= $urandom_range(1);
            key_in  <= $urandom;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic test_empty_pop();
        send_request(CMD_POP, 32'hFFFF_FFFF);
    endtask

    // same key several times into one entry, then drain to an empty pop
    task automatic test_repeated_key();
        repeat (REPEAT_N)
            send_request(CMD_PUSH, key_pool[17]);
        repeat (REPEAT_N + 1)
            send_request(CMD_POP, $urandom);
    endtask

    // fill every entry, drop a new key, bump a held one, pop the largest few
    task automatic test_store_full();
        for (int i = 0; i < ENTRIES; i++)
            send_request(CMD_PUSH, key_pool[i]);
        send_request(CMD_PUSH, key_pool[ENTRIES]);
        send_request(CMD_PUSH, key_pool[0]);
        repeat (3)
            send_request(CMD_POP, 32'h0000_0000);
    endtask

    // blocks of 50 requests with a random push bias so the store fills and drains
    task automatic test_random_mix();
        int               push_pct;
        logic             cmd;
        logic [KEY_W-1:0] key;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                push_pct = $urandom_range(25, 80);
            idle_enable = !(n >= 500 && n < 800);
            cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
            if ($urandom_range(3) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(POOL_N - 1)];
            send_request(cmd, key);
        end
        idle_enable = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result with no request pending: status %0d key_out %h",
                       status, key_out);
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (status !== want_result.status)
                begin
                    errors++;
                    $error("status: expected %0d, actual %0d", want_result.status, status);
                end
                if (key_out !== want_result.key)
                begin
                    errors++;
                    $error("key_out: expected %h, actual %h", want_result.key, key_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        command <= CMD_PUSH;
        key_in  <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pop();
        test_repeated_key();
        test_store_full();
        test_random_mix();
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mpm_pkg.sv
rtl/mpm_store.sv
rtl/mpm_scan.sv
rtl/max_priority_multiset.sv
tb/tb_max_priority_multiset.sv
